FILE: hw/rtl/c8pc_pkg.sv
// Shared types, constants and the CRC-8 byte function for the packet checker
// and link monitor. Used by every module of the block; depends on nothing.
package c8pc_pkg;

   localparam int DEF_MAX_PACKET       = 512;
   localparam int DEF_MAX_VARINT_BYTES = 5;

   localparam logic [7:0] CRC_POLY = 8'hD5;

   localparam logic [2:0] EV_ACCEPTED  = 3'd0;
   localparam logic [2:0] EV_CRC_ERROR = 3'd1;
   localparam logic [2:0] EV_BAD_TYPE  = 3'd2;
   localparam logic [2:0] EV_RUNT      = 3'd3;
   localparam logic [2:0] EV_HEARTBEAT = 3'd4;
   localparam logic [2:0] EV_DISCOVERY = 3'd5;

   localparam logic [2:0] REG_ERROR_LIMIT        = 3'd0;
   localparam logic [2:0] REG_HOST_TIMEOUT       = 3'd1;
   localparam logic [2:0] REG_HEARTBEAT_INTERVAL = 3'd2;
   localparam logic [2:0] REG_DISCOVERY_INTERVAL = 3'd3;
   localparam logic [2:0] REG_HELLO_CODE         = 3'd4;

   localparam logic [7:0]  RST_ERROR_LIMIT        = 8'd10;
   localparam logic [23:0] RST_HOST_TIMEOUT       = 24'd60000;
   localparam logic [23:0] RST_HEARTBEAT_INTERVAL = 24'd2000;
   localparam logic [15:0] RST_DISCOVERY_INTERVAL = 16'd1000;
   localparam logic [6:0]  RST_HELLO_CODE         = 7'd1;

   localparam logic [23:0] TIMER_MAX = 24'hFFFFFF;
   localparam logic [8:0]  ERR_MAX   = 9'd511;

   typedef struct packed {
      logic [7:0]  error_limit;
      logic [23:0] host_timeout;
      logic [23:0] heartbeat_interval;
      logic [15:0] discovery_interval;
      logic [6:0]  hello_code;
   } link_cfg_type;

   typedef struct packed {
      logic [7:0]  crc;
      logic        empty;
      logic        type_done;
      logic [31:0] type_accum;
      logic [8:0]  payload_len;
   } frame_stat_type;

   typedef struct packed {
      logic        emit;
      logic [2:0]  event_res;
      logic [31:0] msg_type;
      logic [8:0]  payload_len;
      logic        host_known;
      logic [31:0] host_address;
      logic [8:0]  error_run;
   } link_res_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] idx);
      logic [7:0] r;
      r = idx;
      for (int b = 0; b < 8; b++) begin
         r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/c8pc_frame.sv
// Per-packet state: running CRC-8, byte count and varint message type decode.
// Depends on c8pc_pkg.
module c8pc_frame
   import c8pc_pkg::*;
#(
   parameter int MAX_PACKET       = DEF_MAX_PACKET,
   parameter int MAX_VARINT_BYTES = DEF_MAX_VARINT_BYTES
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic           kind,
   input  logic [7:0]     data,
   input  logic           last,
   output frame_stat_type stat
);

   localparam int CntW = (MAX_PACKET > 2) ? $clog2(MAX_PACKET) : 1;
   localparam logic [CntW-1:0] CntLimit = CntW'(MAX_PACKET - 1);
   localparam logic [2:0] VarMax = 3'(MAX_VARINT_BYTES);

   logic [7:0]      crc_ff, crc_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [31:0]     accum_ff, accum_in;
   logic [2:0]      tbytes_ff, tbytes_in;
   logic            tdone_ff, tdone_in;
   logic [5:0]      shamt;
   logic [31:0]     part;

   always_comb begin
      crc_in    = crc_ff;
      cnt_in    = cnt_ff;
      accum_in  = accum_ff;
      tbytes_in = tbytes_ff;
      tdone_in  = tdone_ff;
      shamt     = 6'(tbytes_ff) * 6'd7;
      part      = {25'd0, data[6:0]} << shamt[4:0];
      if (step && !kind) begin
         if (last) begin
            crc_in    = '0;
            cnt_in    = '0;
            accum_in  = '0;
            tbytes_in = '0;
            tdone_in  = 1'b0;
         end else if (cnt_ff < CntLimit) begin
            crc_in = crc8_byte(crc_ff ^ data);
            cnt_in = cnt_ff + CntW'(1);
            if (!tdone_ff && tbytes_ff < VarMax) begin
               if (shamt < 6'd32) begin
                  accum_in = accum_ff | part;
               end
               tbytes_in = tbytes_ff + 3'd1;
               if (!data[7]) begin
                  tdone_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= '0;
         cnt_ff    <= '0;
         accum_ff  <= '0;
         tbytes_ff <= '0;
         tdone_ff  <= 1'b0;
      end else begin
         crc_ff    <= crc_in;
         cnt_ff    <= cnt_in;
         accum_ff  <= accum_in;
         tbytes_ff <= tbytes_in;
         tdone_ff  <= tdone_in;
      end
   end

   always_comb begin
      stat.crc         = crc_ff;
      stat.empty       = (cnt_ff == '0);
      stat.type_done   = tdone_ff;
      stat.type_accum  = accum_ff;
      stat.payload_len = 9'(cnt_ff - CntW'(tbytes_ff));
   end

endmodule

FILE: hw/rtl/c8pc_link.sv
// Link state: checksum verdict, error run, host latch and the tick timers.
// Depends on c8pc_pkg and the packet status from c8pc_frame.
module c8pc_link
   import c8pc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic           kind,
   input  logic [7:0]     data,
   input  logic           last,
   input  logic [31:0]    source_addr,
   input  frame_stat_type stat,
   input  link_cfg_type   cfg,
   output link_res_type   res
);

   logic        disc_ff, disc_in;
   logic [31:0] host_ff, host_in;
   logic [8:0]  err_ff, err_in;
   logic [23:0] since_valid_ff, since_valid_in;
   logic [23:0] since_hb_ff, since_hb_in;
   logic [15:0] phase_ff, phase_in;
   logic [16:0] phase_next;
   logic [8:0]  err_inc;

   always_comb begin
      disc_in        = disc_ff;
      host_in        = host_ff;
      err_in         = err_ff;
      since_valid_in = since_valid_ff;
      since_hb_in    = since_hb_ff;
      phase_in       = phase_ff;
      phase_next     = {1'b0, phase_ff} + 17'd1;
      err_inc        = (err_ff < ERR_MAX) ? err_ff + 9'd1 : err_ff;
      res.emit       = 1'b0;
      res.event_res  = EV_ACCEPTED;
      res.msg_type   = '0;
      res.payload_len = '0;
      if (step) begin
         if (kind) begin
            if (since_valid_ff < TIMER_MAX) begin
               since_valid_in = since_valid_ff + 24'd1;
            end
            if (since_hb_ff < TIMER_MAX) begin
               since_hb_in = since_hb_ff + 24'd1;
            end
            phase_in = (phase_next >= {1'b0, cfg.discovery_interval}) ? '0 : phase_next[15:0];
            if (disc_ff && since_valid_in > cfg.host_timeout) begin
               disc_in = 1'b0;
            end
            if (disc_in) begin
               if (since_hb_in > cfg.heartbeat_interval) begin
                  since_hb_in   = '0;
                  res.emit      = 1'b1;
                  res.event_res = EV_HEARTBEAT;
               end
            end else if (phase_ff == '0) begin
               res.emit      = 1'b1;
               res.event_res = EV_DISCOVERY;
            end
         end else if (last) begin
            res.emit = 1'b1;
            if (stat.empty) begin
               res.event_res = EV_RUNT;
            end else if (stat.crc != data) begin
               res.event_res = EV_CRC_ERROR;
               err_in = err_inc;
               if (err_inc > {1'b0, cfg.error_limit}) begin
                  disc_in = 1'b0;
                  err_in  = '0;
               end
            end else if (!stat.type_done) begin
               res.event_res = EV_BAD_TYPE;
               err_in = '0;
            end else begin
               res.event_res   = EV_ACCEPTED;
               res.msg_type    = stat.type_accum;
               res.payload_len = stat.payload_len;
               err_in          = '0;
               since_valid_in  = '0;
               if (stat.type_accum == {25'd0, cfg.hello_code} && !disc_ff) begin
                  host_in = source_addr;
                  disc_in = 1'b1;
               end
            end
         end
      end
      res.host_known   = disc_in;
      res.host_address = host_in;
      res.error_run    = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disc_ff        <= 1'b0;
         host_ff        <= '0;
         err_ff         <= '0;
         since_valid_ff <= '0;
         since_hb_ff    <= '0;
         phase_ff       <= '0;
      end else begin
         disc_ff        <= disc_in;
         host_ff        <= host_in;
         err_ff         <= err_in;
         since_valid_ff <= since_valid_in;
         since_hb_ff    <= since_hb_in;
         phase_ff       <= phase_in;
      end
   end

endmodule

FILE: hw/rtl/crc8_packet_checker_link_monitor_top.sv
// Top level of the CRC-8 packet checker and link monitor: input register,
// configuration registers, c8pc_frame, c8pc_link and the result register.
// Items pass the input register; results then pass the result register.
// Throughput is one item per cycle unless rsp_ready stalls a held result; the
// input and result registers are each a single stage. Reset is synchronous and
// active high; it clears all but the data registers and loads config defaults.
module crc8_packet_checker_link_monitor_top
   import c8pc_pkg::*;
#(
   parameter int MAX_PACKET       = DEF_MAX_PACKET,
   parameter int MAX_VARINT_BYTES = DEF_MAX_VARINT_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_data,
   input  logic        req_last,
   input  logic [31:0] req_source_addr,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [31:0] rsp_msg_type,
   output logic [8:0]  rsp_payload_len,
   output logic        rsp_host_known,
   output logic [31:0] rsp_host_address,
   output logic [8:0]  rsp_error_run
);

   link_cfg_type   cfg_ff;
   logic           in_vld_ff;
   logic           kind_ff;
   logic [7:0]     data_ff;
   logic           last_ff;
   logic [31:0]    src_ff;
   logic           advance;
   frame_stat_type stat;
   link_res_type   res;
   link_res_type   out_ff;
   logic           out_vld_ff, out_vld_in;

   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.error_limit        <= RST_ERROR_LIMIT;
         cfg_ff.host_timeout       <= RST_HOST_TIMEOUT;
         cfg_ff.heartbeat_interval <= RST_HEARTBEAT_INTERVAL;
         cfg_ff.discovery_interval <= RST_DISCOVERY_INTERVAL;
         cfg_ff.hello_code         <= RST_HELLO_CODE;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ERROR_LIMIT:        cfg_ff.error_limit        <= csr_wdata[7:0];
            REG_HOST_TIMEOUT:       cfg_ff.host_timeout       <= csr_wdata;
            REG_HEARTBEAT_INTERVAL: cfg_ff.heartbeat_interval <= csr_wdata;
            REG_DISCOVERY_INTERVAL: cfg_ff.discovery_interval <= csr_wdata[15:0];
            REG_HELLO_CODE:         cfg_ff.hello_code         <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         kind_ff <= req_kind;
         data_ff <= req_data;
         last_ff <= req_last;
         src_ff  <= req_source_addr;
      end
   end

   c8pc_frame #(
      .MAX_PACKET       (MAX_PACKET),
      .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
   ) u_frame (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .kind  (kind_ff),
      .data  (data_ff),
      .last  (last_ff),
      .stat  (stat)
   );

   c8pc_link u_link (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .kind        (kind_ff),
      .data        (data_ff),
      .last        (last_ff),
      .source_addr (src_ff),
      .stat        (stat),
      .cfg         (cfg_ff),
      .res         (res)
   );

   always_comb begin
      out_vld_in = out_vld_ff && !rsp_ready;
      if (advance) begin
         out_vld_in = res.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res.emit) begin
         out_ff <= res;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_event_res    = out_ff.event_res;
   assign rsp_msg_type     = out_ff.msg_type;
   assign rsp_payload_len  = out_ff.payload_len;
   assign rsp_host_known   = out_ff.host_known;
   assign rsp_host_address = out_ff.host_address;
   assign rsp_error_run    = out_ff.error_run;

   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_res <= EV_DISCOVERY)
      else $error("Result event code out of range.");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_ACCEPTED |-> rsp_msg_type == '0 && rsp_payload_len == '0)
      else $error("Non-accepted item carries a type or length.");

   a_heartbeat_host: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_HEARTBEAT |-> rsp_host_known)
      else $error("Heartbeat request without a known host.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !advance || !res.emit)
      else $error("Result register overwritten while stalled.");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for crc8_packet_checker_link_monitor_top: directed
// and random packet, tick and register traffic checked against a cycle-free
// link model. Depends on c8pc_pkg and the top level of the block.
module tb_top;
   import c8pc_pkg::*;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [31:0] msg_type;
      logic [8:0]  payload_len;
      logic        host_known;
      logic [31:0] host_address;
      logic [8:0]  error_run;
   } link_report_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [23:0] csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic        req_kind;
   logic [7:0]  req_data;
   logic        req_last;
   logic [31:0] req_source_addr;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_event_res;
   logic [31:0] rsp_msg_type;
   logic [8:0]  rsp_payload_len;
   logic        rsp_host_known;
   logic [31:0] rsp_host_address;
   logic [8:0]  rsp_error_run;

   logic [7:0]  cfg_err_limit = RST_ERROR_LIMIT;
   logic [23:0] cfg_timeout   = RST_HOST_TIMEOUT;
   logic [23:0] cfg_heartbeat = RST_HEARTBEAT_INTERVAL;
   logic [15:0] cfg_discovery = RST_DISCOVERY_INTERVAL;
   logic [6:0]  cfg_hello     = RST_HELLO_CODE;

   logic [7:0]  frame_crc     = '0;
   logic [9:0]  frame_count   = '0;
   logic [31:0] type_value    = '0;
   logic [2:0]  type_len      = '0;
   logic        type_complete = 1'b0;
   logic        host_seen     = 1'b0;
   logic [31:0] host_latched  = '0;
   logic [8:0]  crc_err_run   = '0;
   logic [23:0] since_valid   = '0;
   logic [23:0] since_beat    = '0;
   logic [15:0] disc_phase    = '0;

   logic [7:0]      crc_lut [256];
   link_report_type expected_reports [$];
   logic [7:0]      frame_body [$];
   int              mismatch_count = 0;
   int              items_sent = 0;
   bit              req_steady = 1'b0;
   bit              rsp_steady = 1'b0;

   crc8_packet_checker_link_monitor_top DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_data         (req_data),
      .req_last         (req_last),
      .req_source_addr  (req_source_addr),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_res    (rsp_event_res),
      .rsp_msg_type     (rsp_msg_type),
      .rsp_payload_len  (rsp_payload_len),
      .rsp_host_known   (rsp_host_known),
      .rsp_host_address (rsp_host_address),
      .rsp_error_run    (rsp_error_run)
   );

   always #5 clock = ~clock;

   initial begin : crc_lut_fill
      logic [7:0] r;
      for (int i = 0; i < 256; i++) begin
         r = 8'(i);
         repeat (8) r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
         crc_lut[i] = r;
      end
   end

   function automatic int pick_gap(input bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic void clear_frame();
      frame_crc     = '0;
      frame_count   = '0;
      type_value    = '0;
      type_len      = '0;
      type_complete = 1'b0;
   endfunction

   function automatic void push_report(input logic [2:0] ev, input logic [31:0] mt,
                                       input logic [8:0] plen);
      link_report_type r;
      r.event_res    = ev;
      r.msg_type     = mt;
      r.payload_len  = plen;
      r.host_known   = host_seen;
      r.host_address = host_latched;
      r.error_run    = crc_err_run;
      expected_reports.push_back(r);
   endfunction

   function automatic void advance_link_model(input logic kind, input logic [7:0] data,
                                              input logic is_last, input logic [31:0] src);
      logic [15:0] old_phase;
      logic [16:0] next_phase;
      logic [9:0]  plen;
      int          shift;
      if (kind) begin
         if (since_valid != TIMER_MAX) since_valid++;
         if (since_beat != TIMER_MAX) since_beat++;
         old_phase  = disc_phase;
         next_phase = {1'b0, disc_phase} + 17'd1;
         disc_phase = (next_phase >= {1'b0, cfg_discovery}) ? 16'd0 : next_phase[15:0];
         if (host_seen && since_valid > cfg_timeout) host_seen = 1'b0;
         if (host_seen) begin
            if (since_beat > cfg_heartbeat) begin
               since_beat = '0;
               push_report(EV_HEARTBEAT, '0, '0);
            end
         end else if (old_phase == 16'd0) begin
            push_report(EV_DISCOVERY, '0, '0);
         end
      end else if (is_last) begin
         if (frame_count == '0) begin
            clear_frame();
            push_report(EV_RUNT, '0, '0);
         end else if (frame_crc != data) begin
            if (crc_err_run != ERR_MAX) crc_err_run++;
            if (crc_err_run > {1'b0, cfg_err_limit}) begin
               host_seen   = 1'b0;
               crc_err_run = '0;
            end
            clear_frame();
            push_report(EV_CRC_ERROR, '0, '0);
         end else begin
            crc_err_run = '0;
            if (!type_complete) begin
               clear_frame();
               push_report(EV_BAD_TYPE, '0, '0);
            end else begin
               plen        = frame_count - {7'd0, type_len};
               since_valid = '0;
               if (type_value == {25'd0, cfg_hello} && !host_seen) begin
                  host_latched = src;
                  host_seen    = 1'b1;
               end
               push_report(EV_ACCEPTED, type_value, plen[8:0]);
               clear_frame();
            end
         end
      end else if (frame_count < 10'(DEF_MAX_PACKET - 1)) begin
         frame_crc = crc_lut[frame_crc ^ data];
         frame_count++;
         if (!type_complete && int'(type_len) < DEF_MAX_VARINT_BYTES) begin
            shift = 7 * int'(type_len);
            if (shift < 32) type_value = type_value | (32'(data[6:0]) << shift);
            type_len++;
            if (!data[7]) type_complete = 1'b1;
         end
      end
   endfunction

   task automatic report_mismatch(input string what, input link_report_type got,
                                  input link_report_type want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("%s %s",
                  $sformatf("%s: got ev=%0d type=%h len=%0d known=%0b host=%h run=%0d;",
                            what, got.event_res, got.msg_type, got.payload_len,
                            got.host_known, got.host_address, got.error_run),
                  $sformatf("expected ev=%0d type=%h len=%0d known=%0b host=%h run=%0d",
                            want.event_res, want.msg_type, want.payload_len,
                            want.host_known, want.host_address, want.error_run));
   endtask

   always @(posedge clock) begin : result_check
      link_report_type got;
      link_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.event_res    = rsp_event_res;
         got.msg_type     = rsp_msg_type;
         got.payload_len  = rsp_payload_len;
         got.host_known   = rsp_host_known;
         got.host_address = rsp_host_address;
         got.error_run    = rsp_error_run;
         if (expected_reports.size() == 0) begin
            report_mismatch("unexpected result", got, got);
         end else begin
            want = expected_reports.pop_front();
            if (got.event_res !== want.event_res || got.msg_type !== want.msg_type ||
                got.payload_len !== want.payload_len || got.host_known !== want.host_known ||
                got.host_address !== want.host_address || got.error_run !== want.error_run)
               report_mismatch("result mismatch", got, want);
         end
      end
   end

   initial begin : rsp_pacing
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = pick_gap(rsp_steady);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   initial begin : watchdog
      #50_000_000;
      $display("crc8_packet_checker_link_monitor_top regression: fail");
      $finish;
   end

   task automatic send_item(input logic kind, input logic [7:0] data, input logic is_last,
                            input logic [31:0] src);
      int gap;
      gap = pick_gap(req_steady);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_data        <= data;
      req_last        <= is_last;
      req_source_addr <= src;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_link_model(kind, data, is_last, src);
      items_sent++;
   endtask

   task automatic send_tick();
      send_item(1'b1, 8'($urandom), 1'($urandom), $urandom);
   endtask

   task automatic send_frame(input logic [31:0] src, input bit corrupt, input int tick_pct);
      logic [7:0] crc;
      crc = '0;
      for (int i = 0; i < frame_body.size() && i < DEF_MAX_PACKET - 1; i++)
         crc = crc_lut[crc ^ frame_body[i]];
      foreach (frame_body[i]) begin
         if ($urandom_range(0, 99) < tick_pct) send_tick();
         send_item(1'b0, frame_body[i], 1'b0, $urandom);
      end
      if (corrupt) crc = crc ^ 8'($urandom_range(1, 255));
      send_item(1'b0, crc, 1'b1, src);
   endtask

   function automatic void load_frame(input logic [63:0] v, input int n);
      frame_body.delete();
      for (int i = 0; i < n; i++) frame_body.push_back(v[8*i +: 8]);
   endfunction

   function automatic void build_random_frame();
      logic [31:0] val;
      logic [7:0]  b;
      int          c;
      int          plen;
      frame_body.delete();
      c = $urandom_range(0, 99);
      if (c < 8) begin
         repeat ($urandom_range(1, 7)) frame_body.push_back(8'h80 | 8'($urandom));
      end else begin
         if (c < 50) val = {25'd0, cfg_hello};
         else if (c < 80) val = $urandom_range(0, 400);
         else val = $urandom;
         do begin
            b   = {1'b0, val[6:0]};
            val = val >> 7;
            if (val != 0) b[7] = 1'b1;
            frame_body.push_back(b);
         end while (val != 0);
         if (frame_body.size() == 5 && $urandom_range(0, 1))
            frame_body[4] = frame_body[4] | {1'b0, 3'($urandom), 4'd0};
         plen = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(5, 24);
         repeat (plen) frame_body.push_back(8'($urandom));
      end
   endfunction

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_ERROR_LIMIT:        cfg_err_limit = val[7:0];
         REG_HOST_TIMEOUT:       cfg_timeout   = val;
         REG_HEARTBEAT_INTERVAL: cfg_heartbeat = val;
         REG_DISCOVERY_INTERVAL: cfg_discovery = val[15:0];
         REG_HELLO_CODE:         cfg_hello     = val[6:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [7:0] err_limit, input logic [23:0] timeout,
                             input logic [23:0] beat, input logic [15:0] disc,
                             input logic [6:0] hello);
      wait_idle();
      write_reg(REG_ERROR_LIMIT, {16'd0, err_limit});
      write_reg(REG_HOST_TIMEOUT, timeout);
      write_reg(REG_HEARTBEAT_INTERVAL, beat);
      write_reg(REG_DISCOVERY_INTERVAL, {8'd0, disc});
      write_reg(REG_HELLO_CODE, {17'd0, hello});
   endtask

   task automatic test_runt();
      send_item(1'b0, 8'hFF, 1'b1, 32'hFFFF_FFFF);
      send_item(1'b0, 8'h00, 1'b1, 32'h0000_0000);
   endtask

   task automatic test_varint_types();
      load_frame(64'h00, 1);
      send_frame(32'h1234_5678, 1'b0, 0);
      load_frame(64'hFF000FFFFFFFFF, 7);
      send_frame(32'h0000_0001, 1'b0, 0);
      load_frame(64'h7FFFFFFFFF, 5);
      send_frame(32'h0000_0002, 1'b0, 0);
      load_frame(64'h008080808080, 6);
      send_frame(32'h0000_0003, 1'b0, 0);
      load_frame(64'h80, 1);
      send_frame(32'h0000_0004, 1'b0, 0);
   endtask

   task automatic test_hello_latch();
      load_frame(64'h01, 1);
      send_frame(32'hA5A5_0001, 1'b0, 0);
      load_frame(64'h5501, 2);
      send_frame(32'h5A5A_0002, 1'b0, 0);
   endtask

   task automatic test_crc_errors();
      load_frame(64'h01, 1);
      repeat (3) send_frame(32'hDEAD_BEEF, 1'b1, 0);
   endtask

   task automatic test_timers();
      load_frame(64'h01, 1);
      send_frame(32'hC0DE_0042, 1'b0, 0);
      repeat (12) send_tick();
   endtask

   task automatic test_oversize_packet();
      frame_body.delete();
      frame_body.push_back(8'h01);
      repeat (519) frame_body.push_back(8'($urandom));
      send_frame($urandom, 1'b0, 0);
   endtask

   task automatic run_random_phase(input int n_items);
      int stop_at;
      int r;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 20) begin
            send_tick();
         end else if (r < 26) begin
            send_item(1'b0, 8'($urandom), 1'($urandom), $urandom);
         end else begin
            build_random_frame();
            send_frame($urandom, $urandom_range(0, 99) < 15, 8);
         end
      end
   endtask

   task automatic test_random_traffic();
      for (int ph = 0; ph < 8; ph++) begin
         req_steady = (ph == 3);
         rsp_steady = (ph == 3 || ph == 5);
         case (ph)
            0: set_config(8'd0, 24'd1, 24'd1, 16'd1, 7'd0);
            1: set_config(8'd255, TIMER_MAX, TIMER_MAX, 16'hFFFF, 7'd127);
            2: set_config(8'($urandom_range(0, 4)), 24'($urandom_range(2, 30)),
                          24'($urandom_range(1, 8)), 16'd0, 7'($urandom));
            default: set_config(8'($urandom_range(0, 12)), 24'($urandom_range(2, 40)),
                                24'($urandom_range(1, 10)), 16'($urandom_range(1, 12)),
                                7'($urandom));
         endcase
         run_random_phase(50);
      end
   endtask

   initial begin
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      req_valid       <= 1'b0;
      req_kind        <= 1'b0;
      req_data        <= '0;
      req_last        <= 1'b0;
      req_source_addr <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      set_config(8'd2, 24'd6, 24'd3, 16'd4, 7'd1);
      test_runt();
      test_varint_types();
      test_hello_latch();
      test_crc_errors();
      test_timers();
      test_oversize_packet();
      test_random_traffic();
      wait_idle();
      if (mismatch_count == 0) begin
         $display("crc8_packet_checker_link_monitor_top regression: pass");
      end else begin
         $display("crc8_packet_checker_link_monitor_top regression: fail");
      end
      $finish;
   end

endmodule

FILE: crc8_packet_checker_link_monitor_top.f
hw/rtl/c8pc_pkg.sv
hw/rtl/c8pc_frame.sv
hw/rtl/c8pc_link.sv
hw/rtl/crc8_packet_checker_link_monitor_top.sv
tb/sv/tb_top.sv
